>>> rtl/mr_pkg.sv
// ============================================================================
// mr_pkg
// Shared types and constants of the Miller-Rabin primality tester.
// ============================================================================
`default_nettype none

package mr_pkg;

  // Arithmetic width of the candidate, the base and all residues.
  localparam int NUM_W = 32;
  // Counter that can hold the value NUM_W itself.
  localparam int CNT_W = $clog2(NUM_W + 1);
  // Counter for the power of two in candidate-1, at most NUM_W-1.
  localparam int K_W   = $clog2(NUM_W);

  // Witness base after reset.
  localparam logic [NUM_W-1:0] BASE_RESET = NUM_W'(67);

  // Result codes.
  typedef enum logic [1:0] {
    V_PRIME         = 2'd0,
    V_COMPOSITE     = 2'd1,
    V_BELOW_TWO     = 2'd2,
    V_BASE_UNUSABLE = 2'd3
  } verdict_t;

  // Operations of the shared modular unit.
  typedef enum logic {
    MM_MUL    = 1'b0,  // x * y mod n
    MM_REDUCE = 1'b1   // y mod n
  } mm_op_t;

  // Command to the modular unit.
  typedef struct packed {
    logic             start;
    mm_op_t           op;
    logic [NUM_W-1:0] x;
    logic [NUM_W-1:0] y;
    logic [NUM_W-1:0] n;
  } mm_cmd_t;

  // Response of the modular unit.
  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] value;
  } mm_rsp_t;

  // Finished verdict from the sequencer.
  typedef struct packed {
    logic             valid;
    verdict_t         verdict;
    logic [NUM_W-1:0] tested;
  } seq_rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED,
    ST_SPLIT,
    ST_POW,
    ST_MUL_R,
    ST_MUL_B,
    ST_TEST_B,
    ST_SQ,
    ST_SQ_WAIT,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/mr_stream_if.sv
// ============================================================================
// mr_stream_if
// Valid/ready channels for candidate items and verdict items.
// ============================================================================
`default_nettype none

interface mr_in_if import mr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface mr_out_if import mr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       verdict;
  logic [NUM_W-1:0] tested_value;

  modport source (output valid, output verdict, output tested_value, input ready);
  modport sink   (input valid, input verdict, input tested_value, output ready);
endinterface

`default_nettype wire

>>> rtl/mr_modmul.sv
// ============================================================================
// mr_modmul
// Shared shift-add modular unit: x*y mod n, one multiplier bit per cycle,
// or y mod n, one bit of y per cycle from the top.
// ============================================================================
`default_nettype none

module mr_modmul import mr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  mm_cmd_t   cmd,
  output mm_rsp_t   rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  mm_op_t           op_r, op_nxt;
  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [NUM_W-1:0] x_r, x_nxt;
  logic [NUM_W-1:0] y_r, y_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W:0]   shl;

  // (a + b) mod n for a, b below n.
  function automatic logic [NUM_W-1:0] mod_add(input logic [NUM_W-1:0] a,
                                               input logic [NUM_W-1:0] b,
                                               input logic [NUM_W-1:0] n);
    logic [NUM_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, n}) begin
      sum = sum - {1'b0, n};
    end
    return sum[NUM_W-1:0];
  endfunction

  // One step per cycle until the multiplier runs out of bits, or, for a reduction, until every bit of y is taken.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    n_nxt    = n_r;
    cnt_nxt  = cnt_r;
    shl      = {acc_r, y_r[NUM_W-1]};
    if (cmd.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      acc_nxt  = '0;
      x_nxt    = cmd.x;
      y_nxt    = cmd.y;
      n_nxt    = cmd.n;
      cnt_nxt  = CNT_W'(NUM_W);
    end else if (busy_r) begin
      case (op_r)
        MM_MUL: begin
          if (y_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            if (y_r[0]) begin
              acc_nxt = mod_add(acc_r, x_r, n_r);
            end
            x_nxt = mod_add(x_r, x_r, n_r);
            y_nxt = y_r >> 1;
          end
        end
        MM_REDUCE: begin
          if (cnt_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            // Horner step: r = 2r + next bit, then one conditional subtract.
            if (shl >= {1'b0, n_r}) begin
              acc_nxt = NUM_W'(shl - {1'b0, n_r});
            end else begin
              acc_nxt = shl[NUM_W-1:0];
            end
            y_nxt   = y_r << 1;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    n_r   <= n_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = acc_r;

`ifndef SYNTH
  // A finished residue is always reduced below the modulus.
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < n_r))
    else $error("modular unit result not below modulus");

  // The sequencer never issues a new operation while one is running.
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("modular unit started while busy");
`endif

endmodule

`default_nettype wire

>>> rtl/mr_seq.sv
// ============================================================================
// mr_seq
// Sequencer of one Miller-Rabin round: special cases, base reduction,
// split of candidate-1, square-and-multiply and the squaring chain.
// ============================================================================
`default_nettype none

module mr_seq import mr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] candidate,
  input  wire logic [NUM_W-1:0] base,
  input  wire logic             take,
  output logic                  idle,
  output seq_rsp_t              rsp,
  output mm_cmd_t               mm_cmd,
  input  mm_rsp_t               mm_rsp
);

  state_t           state_r, state_nxt;
  verdict_t         verdict_r, verdict_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [NUM_W-1:0] a_r, a_nxt;   // reduced base, then running power of it
  logic [NUM_W-1:0] m_r, m_nxt;   // odd part of n-1, then remaining exponent
  logic [NUM_W-1:0] r_r, r_nxt;   // running result, then b of the chain
  logic [K_W-1:0]   k_r, k_nxt;
  logic [K_W-1:0]   i_r, i_nxt;
  logic [NUM_W-1:0] n_less1;

  assign n_less1 = n_r - NUM_W'(1);

  // Next state, datapath updates and unit commands.
  always_comb begin
    state_nxt    = state_r;
    verdict_nxt  = verdict_r;
    n_nxt        = n_r;
    a_nxt        = a_r;
    m_nxt        = m_r;
    r_nxt        = r_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    mm_cmd.start = 1'b0;
    mm_cmd.op    = MM_MUL;
    mm_cmd.x     = a_r;
    mm_cmd.y     = a_r;
    mm_cmd.n     = n_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt     = candidate;
          a_nxt     = base;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_r < NUM_W'(2)) begin
          verdict_nxt = V_BELOW_TWO;
          state_nxt   = ST_RESULT;
        end else if (n_r == NUM_W'(2)) begin
          verdict_nxt = V_PRIME;
          state_nxt   = ST_RESULT;
        end else if (!n_r[0]) begin
          verdict_nxt = V_COMPOSITE;
          state_nxt   = ST_RESULT;
        end else begin
          mm_cmd.start = 1'b1;
          mm_cmd.op    = MM_REDUCE;
          state_nxt    = ST_RED;
        end
      end
      ST_RED: begin
        if (mm_rsp.done) begin
          if (mm_rsp.value == '0) begin
            verdict_nxt = V_BASE_UNUSABLE;
            state_nxt   = ST_RESULT;
          end else begin
            a_nxt     = mm_rsp.value;
            m_nxt     = n_less1;
            k_nxt     = '0;
            state_nxt = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        // Strip one trailing zero a cycle.
        if (!m_r[0]) begin
          m_nxt = m_r >> 1;
          k_nxt = k_r + K_W'(1);
        end else begin
          r_nxt     = NUM_W'(1);
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        if (m_r == '0) begin
          state_nxt = ST_TEST_B;
        end else if (m_r[0]) begin
          mm_cmd.start = 1'b1;
          mm_cmd.x     = r_r;
          state_nxt    = ST_MUL_R;
        end else begin
          mm_cmd.start = 1'b1;
          state_nxt    = ST_MUL_B;
        end
      end
      ST_MUL_R: begin
        if (mm_rsp.done) begin
          r_nxt        = mm_rsp.value;
          mm_cmd.start = 1'b1;
          state_nxt    = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (mm_rsp.done) begin
          a_nxt     = mm_rsp.value;
          m_nxt     = m_r >> 1;
          state_nxt = ST_POW;
        end
      end
      ST_TEST_B: begin
        if (r_r == NUM_W'(1) || r_r == n_less1) begin
          verdict_nxt = V_PRIME;
          state_nxt   = ST_RESULT;
        end else begin
          i_nxt     = K_W'(1);
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (i_r < k_r) begin
          mm_cmd.start = 1'b1;
          mm_cmd.x     = r_r;
          mm_cmd.y     = r_r;
          state_nxt    = ST_SQ_WAIT;
        end else begin
          verdict_nxt = V_COMPOSITE;
          state_nxt   = ST_RESULT;
        end
      end
      ST_SQ_WAIT: begin
        if (mm_rsp.done) begin
          r_nxt = mm_rsp.value;
          if (mm_rsp.value == n_less1) begin
            verdict_nxt = V_PRIME;
            state_nxt   = ST_RESULT;
          end else begin
            i_nxt     = i_r + K_W'(1);
            state_nxt = ST_SQ;
          end
        end
      end
      ST_RESULT: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    n_r       <= n_nxt;
    a_r       <= a_nxt;
    m_r       <= m_nxt;
    r_r       <= r_nxt;
    k_r       <= k_nxt;
    i_r       <= i_nxt;
  end

  assign idle        = (state_r == ST_IDLE);
  assign rsp.valid   = (state_r == ST_RESULT);
  assign rsp.verdict = verdict_r;
  assign rsp.tested  = n_r;

`ifndef SYNTH
  // An odd candidate of at least three leaves at least one factor of two.
  a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POW) |-> (k_r != '0))
    else $error("power of two in candidate-1 is zero");
`endif

endmodule

`default_nettype wire

>>> rtl/miller_rabin_primality_test.sv
// ============================================================================
// miller_rabin_primality_test
// One Miller-Rabin round per candidate against a configured witness base.
// ============================================================================
//
//   Channel   Dir  Handshake        Contents
//   in_if     in   valid/ready      candidate (32 bits)
//   out_if    out  valid/ready      verdict (2 bits), tested_value (32 bits)
//   cfg_*     in   write enable     witness_base (32 bits), reset value 67
//
// One item at a time. Small and even candidates are settled in the check
// state. Odd candidates run on one shared shift-add modular unit, which
// first reduces the base and then forms each modular product at one
// multiplier bit per cycle.
// The output register holds a finished item while the next is accepted.
// Reset is synchronous and active low; no clearing pass is needed.
// ============================================================================
`default_nettype none

module miller_rabin_primality_test import mr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  mr_in_if.sink                 in_if,
  mr_out_if.source              out_if,
  input  wire logic             cfg_we,
  input  wire logic [NUM_W-1:0] cfg_wdata
);

  logic [NUM_W-1:0] base_r;
  logic             out_valid_r, out_valid_nxt;
  verdict_t         verdict_r;
  logic [NUM_W-1:0] tested_r;
  logic             seq_idle;
  logic             load;
  seq_rsp_t         seq_rsp;
  mm_cmd_t          mm_cmd;
  mm_rsp_t          mm_rsp;

  // Witness base register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  assign in_if.ready = seq_idle;

  mr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_if.valid && seq_idle),
    .candidate (in_if.candidate),
    .base      (base_r),
    .take      (load),
    .idle      (seq_idle),
    .rsp       (seq_rsp),
    .mm_cmd    (mm_cmd),
    .mm_rsp    (mm_rsp)
  );

  mr_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mm_cmd),
    .rsp   (mm_rsp)
  );

  // Output register: loads a finished item when empty or being drained.
  assign load = seq_rsp.valid && (!out_valid_r || out_if.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= seq_rsp.verdict;
      tested_r  <= seq_rsp.tested;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.verdict      = verdict_r;
  assign out_if.tested_value = tested_r;

`ifndef SYNTH
  // An accepted item keeps the sequencer busy on the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !seq_idle)
    else $error("sequencer idle right after an accepted item");
`endif

endmodule

`default_nettype wire
